// ----- rtl/core/u8d_pkg.sv -----
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to code point decoder: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 32;
    localparam int unsigned CNT_W  = 3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic result;
        logic stg_vld;
        logic out_free;
        logic last;
    } t_sts;

endpackage

// ----- rtl/core/u8d_ctrl.sv -----
// ----------------------------------------------------------------------------
// u8d_ctrl
// Sequencer: takes one byte, then steps the scan of the held bytes once per
// cycle until it ends, stalling while the output register is occupied.
// ----------------------------------------------------------------------------
module u8d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  u8d_pkg::t_sts i_sts,
    output u8d_pkg::t_cmd o_cmd
);

    u8d_pkg::t_state r_state;
    u8d_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8d_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            u8d_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = u8d_pkg::ST_SCAN;
                end
            end
            u8d_pkg::ST_SCAN: begin
                if (i_sts.result) begin
                    if (!i_sts.stg_vld || i_sts.out_free) begin
                        o_cmd.step = 1'b1;
                    end
                end else if (!(i_sts.stg_vld || i_sts.last) || i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = u8d_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = u8d_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/u8d_datapath.sv -----
// ----------------------------------------------------------------------------
// u8d_datapath
// Byte buffer, scan step decode, staging result and output register. One
// result is held back in staging until it is known whether it ends the run.
// ----------------------------------------------------------------------------
module u8d_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  u8d_pkg::t_cmd               i_cmd,
    output u8d_pkg::t_sts               o_sts,
    input  logic [u8d_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_last,
    input  logic                        i_cfg_wr_en,
    input  logic [u8d_pkg::CP_W-1:0]    i_cfg_wr_data,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [u8d_pkg::CP_W-1:0]    o_m_tdata,
    output logic                        o_m_tlast,
    output logic [1:0]                  o_m_tuser
);

    localparam logic [7:0] LIM_ASCII = 8'h80;
    localparam logic [7:0] LIM_BAD   = 8'hC2;
    localparam logic [7:0] LIM_TWO   = 8'hE0;
    localparam logic [7:0] LIM_THREE = 8'hF0;
    localparam logic [7:0] LIM_STOP  = 8'hF5;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    logic [u8d_pkg::BYTE_W-1:0] r_buf [4];
    logic [u8d_pkg::BYTE_W-1:0] n_buf [4];
    logic [u8d_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_stopped;
    logic                       r_last;
    logic [u8d_pkg::CP_W-1:0]   r_marker;
    logic [u8d_pkg::CP_W-1:0]   r_stg_cp;
    logic                       r_stg_vld;
    logic                       r_out_vld;
    logic [u8d_pkg::CP_W-1:0]   r_out_cp;
    logic                       r_out_has;
    logic                       r_out_run_last;
    logic                       r_out_done;

    logic [7:0]                 lead;
    logic [u8d_pkg::CNT_W-1:0]  need;
    logic [u8d_pkg::CNT_W-1:0]  drop;
    logic                       cont_ok;
    logic                       res;
    logic                       stop;
    logic [u8d_pkg::CP_W-1:0]   res_cp;
    logic                       out_free;

    always_comb begin
        lead = r_buf[0];
        if (lead < LIM_TWO) begin
            need = 3'd2;
        end else if (lead < LIM_THREE) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
        cont_ok = ((r_buf[1] & CONT_MASK) == CONT_TAG)
               && (need < 3'd3 || (r_buf[2] & CONT_MASK) == CONT_TAG)
               && (need < 3'd4 || (r_buf[3] & CONT_MASK) == CONT_TAG);
        res    = 1'b0;
        stop   = 1'b0;
        drop   = 3'd1;
        res_cp = '0;
        if (r_cnt == '0) begin
            res = 1'b0;
        end else if (lead < LIM_ASCII) begin
            res    = 1'b1;
            res_cp = {24'd0, lead};
        end else if (lead < LIM_BAD) begin
            res    = 1'b1;
            res_cp = r_marker;
        end else if (lead >= LIM_STOP) begin
            stop = 1'b1;
        end else if (r_cnt < need) begin
            res = 1'b0;
        end else if (!cont_ok) begin
            res    = 1'b1;
            res_cp = r_marker;
        end else begin
            res  = 1'b1;
            drop = need;
            case (need)
                3'd2: res_cp = {21'd0, lead[4:0], r_buf[1][5:0]};
                3'd3: res_cp = {16'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
                default: res_cp = {11'd0, lead[2:0], r_buf[1][5:0], r_buf[2][5:0],
                                   r_buf[3][5:0]};
            endcase
        end
    end

    always_comb begin
        n_buf = r_buf;
        if (i_cmd.load) begin
            n_buf[r_cnt[1:0]] = i_byte;
        end else if (i_cmd.step) begin
            case (drop)
                3'd1: begin
                    n_buf[0] = r_buf[1];
                    n_buf[1] = r_buf[2];
                    n_buf[2] = r_buf[3];
                end
                3'd2: begin
                    n_buf[0] = r_buf[2];
                    n_buf[1] = r_buf[3];
                end
                3'd3: begin
                    n_buf[0] = r_buf[3];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_vld || i_m_tready;

    always_comb begin
        o_sts.result   = res;
        o_sts.stg_vld  = r_stg_vld;
        o_sts.out_free = out_free;
        o_sts.last     = r_last;
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (i_cmd.load) begin
            r_last <= i_last;
        end
        if (i_cmd.step) begin
            r_stg_cp <= res_cp;
            if (r_stg_vld) begin
                r_out_cp       <= r_stg_cp;
                r_out_has      <= 1'b1;
                r_out_run_last <= 1'b0;
                r_out_done     <= 1'b0;
            end
        end
        if (i_cmd.finish && (r_stg_vld || r_last)) begin
            r_out_cp       <= r_stg_vld ? r_stg_cp : '0;
            r_out_has      <= r_stg_vld;
            r_out_run_last <= 1'b1;
            r_out_done     <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_marker  <= '1;
        end else begin
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end
            if ((i_cmd.step && r_stg_vld)
                    || (i_cmd.finish && (r_stg_vld || r_last))) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.load && !r_stopped) begin
                r_cnt <= r_cnt + 3'd1;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt - drop;
            end else if (i_cmd.finish && (r_last || stop)) begin
                r_cnt <= '0;
            end
            if (i_cmd.step) begin
                r_stg_vld <= 1'b1;
            end else if (i_cmd.finish) begin
                r_stg_vld <= 1'b0;
            end
            if (i_cmd.finish && r_last) begin
                r_stopped <= 1'b0;
            end else if (i_cmd.finish && stop) begin
                r_stopped <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_cp;
    assign o_m_tlast  = r_out_run_last;
    assign o_m_tuser  = {r_out_done, r_out_has};

endmodule

// ----- rtl/core/utf8_to_codepoint_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Decodes a UTF-8 byte stream into code points, one byte taken at a time.
// ----------------------------------------------------------------------------
// A result passes from the byte buffer through the staging register to the
// output register. A new byte is taken only after the scan of the held bytes
// has ended; the sequencer steps that scan over the results the byte releases.
// Output back-pressure stalls the scan once a second result is waiting.
// Reset (synchronous, active low) empties the buffer, clears the stop and
// output valid, and sets the invalid marker to all ones.
module utf8_to_codepoint_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code_point
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // [0] has_code_point, [1] string_done
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    u8d_pkg::t_cmd cmd;
    u8d_pkg::t_sts sts;

    u8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    u8d_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tlast     (m_axis_tlast),
        .o_m_tuser     (m_axis_tuser)
    );

endmodule

// ----- rtl/core/u8d_checker.sv -----
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled transfer changed");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("string end without run end");

    a_empty_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata == 32'd0 && m_axis_tlast && m_axis_tuser[1])
        else $error("malformed empty end notice");

    a_one_byte_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("byte taken while previous still scanned");

endmodule

bind utf8_to_codepoint_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
